@@ rtl/i2cm_pkg.sv @@
`default_nettype none
package i2cm_pkg;

   localparam int BYTE_W   = 8;
   localparam int BIT_CNT_W = 4;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

   localparam logic [BYTE_W-1:0] STRETCH_LIMIT_RESET = 8'd200;
   localparam logic [BYTE_W-1:0] ACK_HOLD_RESET      = 8'd50;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_NACK    = 2'd1,
      ST_TIMEOUT = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STRETCH_LIMIT = 2'd0,
      CSR_ACK_HOLD      = 2'd1
   } csr_index_type;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'd0,
      PH_S_REL_SDA = 5'd1,
      PH_S_REL_SCL = 5'd2,
      PH_S_WAIT    = 5'd3,
      PH_S_SDA_LOW = 5'd4,
      PH_S_SCL_LOW = 5'd5,
      PH_P_SDA_LOW = 5'd6,
      PH_P_REL_SCL = 5'd7,
      PH_P_WAIT    = 5'd8,
      PH_P_REL_SDA = 5'd9,
      PH_W_DATA    = 5'd10,
      PH_W_REL_SCL = 5'd11,
      PH_W_WAIT    = 5'd12,
      PH_W_SCL_LOW = 5'd13,
      PH_A_REL_SDA = 5'd14,
      PH_A_REL_SCL = 5'd15,
      PH_A_WAIT    = 5'd16,
      PH_A_SAMPLE  = 5'd17,
      PH_R_REL_SDA = 5'd18,
      PH_R_REL_SCL = 5'd19,
      PH_R_WAIT    = 5'd20,
      PH_R_SCL_LOW = 5'd21,
      PH_K_SDA     = 5'd22,
      PH_K_REL_SCL = 5'd23,
      PH_K_WAIT    = 5'd24,
      PH_K_HOLD    = 5'd25,
      PH_K_SCL_LOW = 5'd26
   } phase_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] wr_byte;
      logic              send_ack;
      logic              scl_in;
      logic              sda_in;
   } req_word_type;

   typedef struct packed {
      logic                scl_drive_low;
      logic                sda_drive_low;
      logic                busy_res;
      logic                done_res;
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   rx_byte;
   } rsp_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0] stretch_limit;
      logic [BYTE_W-1:0] ack_hold_ticks;
   } cfg_type;

endpackage
`default_nettype wire

@@ rtl/i2cm_req_if.sv @@
`default_nettype none
interface i2cm_req_if import i2cm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [BYTE_W-1:0] wr_byte;
   logic              send_ack;
   logic              scl_in;
   logic              sda_in;

   modport source (output valid, cmd, wr_byte, send_ack, scl_in, sda_in, input ready);
   modport sink   (input valid, cmd, wr_byte, send_ack, scl_in, sda_in, output ready);
endinterface
`default_nettype wire

@@ rtl/i2cm_rsp_if.sv @@
`default_nettype none
interface i2cm_rsp_if import i2cm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                scl_drive_low;
   logic                sda_drive_low;
   logic                busy_res;
   logic                done_res;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   rx_byte;

   modport source (output valid, scl_drive_low, sda_drive_low, busy_res, done_res, status,
                   rx_byte, input ready);
   modport sink   (input valid, scl_drive_low, sda_drive_low, busy_res, done_res, status,
                   rx_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/i2cm_csr_if.sv @@
`default_nettype none
interface i2cm_csr_if import i2cm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [BYTE_W-1:0]    wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

@@ rtl/i2cm_csr.sv @@
`default_nettype none
module i2cm_csr import i2cm_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   i2cm_csr_if.sink   csr_ch,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.reg_index)
            CSR_STRETCH_LIMIT: cfg_in.stretch_limit  = csr_ch.wr_data;
            CSR_ACK_HOLD:      cfg_in.ack_hold_ticks = csr_ch.wr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stretch_limit  <= STRETCH_LIMIT_RESET;
         cfg_ff.ack_hold_ticks <= ACK_HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/i2cm_core.sv @@
`default_nettype none
module i2cm_core import i2cm_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire req_word_type  req_word,
   input  wire cfg_type       cfg,
   output rsp_word_type       rsp_word
);

   phase_type            phase_ff, phase_in;
   logic [BIT_CNT_W-1:0] bit_count_ff, bit_count_in;
   logic [BYTE_W-1:0]    shift_byte_ff, shift_byte_in;
   logic [BYTE_W-1:0]    stretch_count_ff, stretch_count_in;
   logic [BYTE_W-1:0]    hold_count_ff, hold_count_in;
   logic                 read_ack_mode_ff, read_ack_mode_in;
   logic                 scl_low_ff, scl_low_in;
   logic                 sda_low_ff, sda_low_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [BYTE_W-1:0]    rx_ff, rx_in;
   logic                 is_read_ff, is_read_in;
   logic                 done;

   always_comb begin
      phase_type ph;
      phase_type wait_next;
      logic      wait_phase;

      ph               = phase_ff;
      wait_next        = PH_IDLE;
      wait_phase       = 1'b0;
      phase_in         = phase_ff;
      bit_count_in     = bit_count_ff;
      shift_byte_in    = shift_byte_ff;
      stretch_count_in = stretch_count_ff;
      hold_count_in    = hold_count_ff;
      read_ack_mode_in = read_ack_mode_ff;
      scl_low_in       = scl_low_ff;
      sda_low_in       = sda_low_ff;
      status_in        = status_ff;
      rx_in            = rx_ff;
      is_read_in       = is_read_ff;
      done             = 1'b0;

      if (phase_ff == PH_IDLE) begin
         is_read_in = 1'b0;
         case (req_word.cmd)
            CMD_START: ph = PH_S_REL_SDA;
            CMD_STOP:  ph = PH_P_SDA_LOW;
            CMD_WRITE: begin
               shift_byte_in = req_word.wr_byte;
               bit_count_in  = BITS_PER_BYTE;
               ph            = PH_W_DATA;
            end
            CMD_READ: begin
               shift_byte_in    = '0;
               bit_count_in     = BITS_PER_BYTE;
               read_ack_mode_in = req_word.send_ack;
               is_read_in       = 1'b1;
               ph               = PH_R_REL_SDA;
            end
            default: ph = PH_IDLE;
         endcase
      end
      phase_in = ph;

      case (ph)
         PH_S_REL_SDA: begin
            sda_low_in = 1'b0;
            phase_in   = PH_S_REL_SCL;
         end
         PH_S_REL_SCL: begin
            scl_low_in = 1'b0; stretch_count_in = '0; phase_in = PH_S_WAIT;
         end
         PH_S_WAIT: begin
            wait_phase = 1'b1; wait_next = PH_S_SDA_LOW;
         end
         PH_S_SDA_LOW: begin
            sda_low_in = 1'b1;
            phase_in   = PH_S_SCL_LOW;
         end
         PH_S_SCL_LOW: begin
            scl_low_in = 1'b1; status_in = ST_OK; phase_in = PH_IDLE; done = 1'b1;
         end
         PH_P_SDA_LOW: begin
            sda_low_in = 1'b1;
            phase_in   = PH_P_REL_SCL;
         end
         PH_P_REL_SCL: begin
            scl_low_in = 1'b0; stretch_count_in = '0; phase_in = PH_P_WAIT;
         end
         PH_P_WAIT: begin
            wait_phase = 1'b1; wait_next = PH_P_REL_SDA;
         end
         PH_P_REL_SDA: begin
            sda_low_in = 1'b0; status_in = ST_OK; phase_in = PH_IDLE; done = 1'b1;
         end
         PH_W_DATA: begin
            sda_low_in = ~shift_byte_in[BYTE_W-1];
            phase_in   = PH_W_REL_SCL;
         end
         PH_W_REL_SCL: begin
            scl_low_in = 1'b0; stretch_count_in = '0; phase_in = PH_W_WAIT;
         end
         PH_W_WAIT: begin
            wait_phase = 1'b1; wait_next = PH_W_SCL_LOW;
         end
         PH_W_SCL_LOW: begin
            scl_low_in    = 1'b1;
            shift_byte_in = {shift_byte_ff[BYTE_W-2:0], 1'b0};
            bit_count_in  = bit_count_ff - 4'd1;
            phase_in      = (bit_count_in == '0) ? PH_A_REL_SDA : PH_W_DATA;
         end
         PH_A_REL_SDA: begin
            sda_low_in = 1'b0;
            phase_in   = PH_A_REL_SCL;
         end
         PH_A_REL_SCL: begin
            scl_low_in = 1'b0; stretch_count_in = '0; phase_in = PH_A_WAIT;
         end
         PH_A_WAIT: begin
            wait_phase = 1'b1; wait_next = PH_A_SAMPLE;
         end
         PH_A_SAMPLE: begin
            scl_low_in = 1'b1;
            status_in  = req_word.sda_in ? ST_NACK : ST_OK;
            phase_in   = PH_IDLE;
            done       = 1'b1;
         end
         PH_R_REL_SDA: begin
            sda_low_in = 1'b0;
            phase_in   = PH_R_REL_SCL;
         end
         PH_R_REL_SCL: begin
            scl_low_in = 1'b0; stretch_count_in = '0; phase_in = PH_R_WAIT;
         end
         PH_R_WAIT: begin
            wait_phase = 1'b1; wait_next = PH_R_SCL_LOW;
         end
         PH_R_SCL_LOW: begin
            scl_low_in   = 1'b1;
            bit_count_in = bit_count_ff - 4'd1;
            phase_in     = (bit_count_in == '0) ? PH_K_SDA : PH_R_REL_SCL;
         end
         PH_K_SDA: begin
            sda_low_in = read_ack_mode_ff;
            phase_in   = PH_K_REL_SCL;
         end
         PH_K_REL_SCL: begin
            scl_low_in = 1'b0; stretch_count_in = '0; phase_in = PH_K_WAIT;
         end
         PH_K_WAIT: begin
            wait_phase = 1'b1; wait_next = PH_K_HOLD;
         end
         PH_K_HOLD: begin
            if (hold_count_ff != '1) begin
               hold_count_in = hold_count_ff + 8'd1;
            end
            if (hold_count_in >= cfg.ack_hold_ticks) begin
               phase_in = PH_K_SCL_LOW;
            end
         end
         PH_K_SCL_LOW: begin
            scl_low_in = 1'b1;
            rx_in      = shift_byte_ff;
            status_in  = ST_OK;
            phase_in   = PH_IDLE;
            done       = 1'b1;
         end
         default: phase_in = PH_IDLE;
      endcase

      // clock stretch wait, shared by all wait phases
      if (wait_phase) begin
         if (req_word.scl_in) begin
            phase_in = wait_next;
            if (ph == PH_R_WAIT) begin
               shift_byte_in = {shift_byte_ff[BYTE_W-2:0], req_word.sda_in};
            end
            if (ph == PH_K_WAIT) begin
               hold_count_in = '0;
            end
         end else if (stretch_count_ff >= cfg.stretch_limit) begin
            scl_low_in = 1'b0;
            sda_low_in = 1'b0;
            status_in  = ST_TIMEOUT;
            if (is_read_in) begin
               rx_in = '0;
            end
            phase_in = PH_IDLE;
            done     = 1'b1;
         end else begin
            stretch_count_in = stretch_count_ff + 8'd1;
         end
      end
   end

   always_comb begin
      rsp_word.scl_drive_low = scl_low_in;
      rsp_word.sda_drive_low = sda_low_in;
      rsp_word.busy_res      = (phase_in != PH_IDLE);
      rsp_word.done_res      = done;
      rsp_word.status        = status_in;
      rsp_word.rx_byte       = rx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         bit_count_ff     <= '0;
         shift_byte_ff    <= '0;
         stretch_count_ff <= '0;
         hold_count_ff    <= '0;
         read_ack_mode_ff <= 1'b0;
         scl_low_ff       <= 1'b0;
         sda_low_ff       <= 1'b0;
         status_ff        <= ST_OK;
         rx_ff            <= '0;
         is_read_ff       <= 1'b0;
      end else if (step) begin
         phase_ff         <= phase_in;
         bit_count_ff     <= bit_count_in;
         shift_byte_ff    <= shift_byte_in;
         stretch_count_ff <= stretch_count_in;
         hold_count_ff    <= hold_count_in;
         read_ack_mode_ff <= read_ack_mode_in;
         scl_low_ff       <= scl_low_in;
         sda_low_ff       <= sda_low_in;
         status_ff        <= status_in;
         rx_ff            <= rx_in;
         is_read_ff       <= is_read_in;
      end
   end

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      step && done |-> !rsp_word.busy_res)
      else $error("done with busy still set");

   a_done_from_active: assert property (@(posedge clock) disable iff (reset)
      step && done |-> phase_ff != PH_IDLE)
      else $error("command finished on the tick it was issued");

   a_idle_after_done: assert property (@(posedge clock) disable iff (reset)
      step && done |=> phase_ff == PH_IDLE)
      else $error("engine not idle after done");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= BITS_PER_BYTE)
      else $error("bit counter out of range");

endmodule
`default_nettype wire

@@ rtl/i2c_master_byte_engine.sv @@
// channel  | dir | fields
// req_ch   | in  | cmd, wr_byte, send_ack, scl_in, sda_in
// rsp_ch   | out | scl_drive_low, sda_drive_low, busy_res, done_res, status, rx_byte
// csr_ch   | in  | reg_index (0 stretch_limit, 1 ack_hold_ticks), wr_data
//
// One word per clock unless rsp_ch stalls; each accepted word yields one result word.
// The line state machine steps once as a word moves from the input register
// to the output register; that single step sets the rate.
// Synchronous active-high reset: engine idle, both lines released, limits 200 / 50.
// A stall on rsp_ch holds the output register and backs up into the input register.
`default_nettype none
module i2c_master_byte_engine import i2cm_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   i2cm_req_if.sink   req_ch,
   i2cm_rsp_if.source rsp_ch,
   i2cm_csr_if.sink   csr_ch
);

   cfg_type      cfg;
   req_word_type req_word;
   rsp_word_type step_word;

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff;
   logic         step;
   logic         take;

   i2cm_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   i2cm_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .req_word (in_word_ff),
      .cfg      (cfg),
      .rsp_word (step_word)
   );

   always_comb begin
      req_word.cmd      = req_ch.cmd;
      req_word.wr_byte  = req_ch.wr_byte;
      req_word.send_ack = req_ch.send_ack;
      req_word.scl_in   = req_ch.scl_in;
      req_word.sda_in   = req_ch.sda_in;
   end

   assign step         = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || step;
   assign take         = req_ch.valid && req_ch.ready;
   assign in_valid_in  = take || (in_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_word_ff <= req_word;
      end
      if (step) begin
         rsp_word_ff <= step_word;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.scl_drive_low = rsp_word_ff.scl_drive_low;
   assign rsp_ch.sda_drive_low = rsp_word_ff.sda_drive_low;
   assign rsp_ch.busy_res      = rsp_word_ff.busy_res;
   assign rsp_ch.done_res      = rsp_word_ff.done_res;
   assign rsp_ch.status        = rsp_word_ff.status;
   assign rsp_ch.rx_byte       = rsp_word_ff.rx_byte;

endmodule
`default_nettype wire

@@ test/i2cm_line_checker.sv @@
`timescale 1ns / 1ps
module i2cm_line_checker import i2cm_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   i2cm_req_if       req_mon,
   i2cm_rsp_if       rsp_mon,
   i2cm_csr_if       csr_mon,
   output int        fail_count,
   output int        exp_pending,
   output logic      engine_busy,
   output int        done_seen,
   output int        nack_seen,
   output int        timeout_seen
);

   logic [BYTE_W-1:0]    lim_stretch;
   logic [BYTE_W-1:0]    lim_hold;

   phase_type            ph;
   logic [BIT_CNT_W-1:0] bits_left;
   logic [BYTE_W-1:0]    shreg;
   logic [BYTE_W-1:0]    stretch_cnt;
   logic [BYTE_W-1:0]    hold_cnt;
   logic                 ack_mode;
   logic                 scl_low;
   logic                 sda_low;
   logic                 is_read;
   logic                 step_done;
   logic [STATUS_W-1:0]  last_status;
   logic [BYTE_W-1:0]    last_rx;

   rsp_word_type         line_words[$];
   int                   errs = 0;
   int                   n_done = 0;
   int                   n_nack = 0;
   int                   n_timeout = 0;

   function automatic void reset_engine_model();
      lim_stretch = STRETCH_LIMIT_RESET;
      lim_hold    = ACK_HOLD_RESET;
      ph          = PH_IDLE;
      bits_left   = '0;
      shreg       = '0;
      stretch_cnt = '0;
      hold_cnt    = '0;
      ack_mode    = 1'b0;
      scl_low     = 1'b0;
      sda_low     = 1'b0;
      is_read     = 1'b0;
      step_done   = 1'b0;
      last_status = ST_OK;
      last_rx     = '0;
   endfunction

   function automatic void free_scl(input phase_type nxt);
      scl_low     = 1'b0;
      stretch_cnt = '0;
      ph          = nxt;
   endfunction

   function automatic void end_command(input status_type st);
      last_status = st;
      ph          = PH_IDLE;
      step_done   = 1'b1;
   endfunction

   // one wait tick; a low SCL counts against the stretch limit
   function automatic logic scl_seen_high(input logic scl);
      if (scl)
         return 1'b1;
      if (stretch_cnt >= lim_stretch) begin
         scl_low     = 1'b0;
         sda_low     = 1'b0;
         last_status = ST_TIMEOUT;
         if (is_read)
            last_rx = '0;
         ph        = PH_IDLE;
         step_done = 1'b1;
      end else begin
         stretch_cnt = stretch_cnt + 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_word_type step_line_engine(input req_word_type w);
      rsp_word_type r;
      step_done = 1'b0;
      if (ph == PH_IDLE) begin
         is_read = 1'b0;
         case (w.cmd)
            CMD_START: ph = PH_S_REL_SDA;
            CMD_STOP:  ph = PH_P_SDA_LOW;
            CMD_WRITE: begin
               shreg     = w.wr_byte;
               bits_left = BITS_PER_BYTE;
               ph        = PH_W_DATA;
            end
            CMD_READ: begin
               shreg     = '0;
               bits_left = BITS_PER_BYTE;
               ack_mode  = w.send_ack;
               is_read   = 1'b1;
               ph        = PH_R_REL_SDA;
            end
            default: ;
         endcase
      end

      case (ph)
         PH_S_REL_SDA: begin
            sda_low = 1'b0;
            ph      = PH_S_REL_SCL;
         end
         PH_S_REL_SCL: free_scl(PH_S_WAIT);
         PH_S_WAIT: if (scl_seen_high(w.scl_in)) ph = PH_S_SDA_LOW;
         PH_S_SDA_LOW: begin
            sda_low = 1'b1;
            ph      = PH_S_SCL_LOW;
         end
         PH_S_SCL_LOW: begin
            scl_low = 1'b1;
            end_command(ST_OK);
         end
         PH_P_SDA_LOW: begin
            sda_low = 1'b1;
            ph      = PH_P_REL_SCL;
         end
         PH_P_REL_SCL: free_scl(PH_P_WAIT);
         PH_P_WAIT: if (scl_seen_high(w.scl_in)) ph = PH_P_REL_SDA;
         PH_P_REL_SDA: begin
            sda_low = 1'b0;
            end_command(ST_OK);
         end
         PH_W_DATA: begin
            sda_low = ~shreg[BYTE_W-1];
            ph      = PH_W_REL_SCL;
         end
         PH_W_REL_SCL: free_scl(PH_W_WAIT);
         PH_W_WAIT: if (scl_seen_high(w.scl_in)) ph = PH_W_SCL_LOW;
         PH_W_SCL_LOW: begin
            scl_low   = 1'b1;
            shreg     = shreg << 1;
            bits_left = bits_left - 1'b1;
            ph        = (bits_left == 0) ? PH_A_REL_SDA : PH_W_DATA;
         end
         PH_A_REL_SDA: begin
            sda_low = 1'b0;
            ph      = PH_A_REL_SCL;
         end
         PH_A_REL_SCL: free_scl(PH_A_WAIT);
         PH_A_WAIT: if (scl_seen_high(w.scl_in)) ph = PH_A_SAMPLE;
         PH_A_SAMPLE: begin
            scl_low = 1'b1;
            end_command(w.sda_in ? ST_NACK : ST_OK);
         end
         PH_R_REL_SDA: begin
            sda_low = 1'b0;
            ph      = PH_R_REL_SCL;
         end
         PH_R_REL_SCL: free_scl(PH_R_WAIT);
         PH_R_WAIT: begin
            if (scl_seen_high(w.scl_in)) begin
               shreg = {shreg[BYTE_W-2:0], w.sda_in};
               ph    = PH_R_SCL_LOW;
            end
         end
         PH_R_SCL_LOW: begin
            scl_low   = 1'b1;
            bits_left = bits_left - 1'b1;
            ph        = (bits_left == 0) ? PH_K_SDA : PH_R_REL_SCL;
         end
         PH_K_SDA: begin
            sda_low = ack_mode;
            ph      = PH_K_REL_SCL;
         end
         PH_K_REL_SCL: free_scl(PH_K_WAIT);
         PH_K_WAIT: begin
            if (scl_seen_high(w.scl_in)) begin
               hold_cnt = '0;
               ph       = PH_K_HOLD;
            end
         end
         PH_K_HOLD: begin
            if (hold_cnt < 8'hFF)
               hold_cnt = hold_cnt + 1'b1;
            if (hold_cnt >= lim_hold)
               ph = PH_K_SCL_LOW;
         end
         PH_K_SCL_LOW: begin
            scl_low = 1'b1;
            last_rx = shreg;
            end_command(ST_OK);
         end
         default: ph = PH_IDLE;
      endcase

      r.scl_drive_low = scl_low;
      r.sda_drive_low = sda_low;
      r.busy_res      = (ph != PH_IDLE);
      r.done_res      = step_done;
      r.status        = last_status;
      r.rx_byte       = last_rx;
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         errs++;
         $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      req_word_type w;
      rsp_word_type want;
      rsp_word_type got;
      if (reset) begin
         reset_engine_model();
         line_words.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.reg_index)
               CSR_STRETCH_LIMIT: lim_stretch = csr_mon.wr_data;
               CSR_ACK_HOLD:      lim_hold    = csr_mon.wr_data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.scl_drive_low, rsp_mon.sda_drive_low, rsp_mon.busy_res,
                   rsp_mon.done_res, rsp_mon.status, rsp_mon.rx_byte};
            if (got.done_res) begin
               n_done++;
               if (got.status == ST_NACK)
                  n_nack++;
               if (got.status == ST_TIMEOUT)
                  n_timeout++;
            end
            if (line_words.size() == 0) begin
               errs++;
               $display("%0t unexpected result word: expected none, actual %h", $time, got);
            end else begin
               want = line_words.pop_front();
               check_field("scl_drive_low", want.scl_drive_low, got.scl_drive_low);
               check_field("sda_drive_low", want.sda_drive_low, got.sda_drive_low);
               check_field("busy_res", want.busy_res, got.busy_res);
               check_field("done_res", want.done_res, got.done_res);
               check_field("status", want.status, got.status);
               check_field("rx_byte", want.rx_byte, got.rx_byte);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            w = {req_mon.cmd, req_mon.wr_byte, req_mon.send_ack, req_mon.scl_in,
                 req_mon.sda_in};
            line_words.push_back(step_line_engine(w));
         end
      end
      fail_count   <= errs;
      exp_pending  <= line_words.size();
      engine_busy  <= (ph != PH_IDLE);
      done_seen    <= n_done;
      nack_seen    <= n_nack;
      timeout_seen <= n_timeout;
   end

endmodule

@@ test/i2c_master_byte_engine_tb.sv @@
`timescale 1ns / 1ps
module i2c_master_byte_engine_tb;
   import i2cm_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int LONG_HOLD   = 400;
   localparam int ITEMS       = 400;

   logic clock;
   logic reset;

   i2cm_req_if req_bus ();
   i2cm_rsp_if rsp_bus ();
   i2cm_csr_if csr_bus ();

   int   fail_count;
   int   exp_pending;
   logic engine_busy;
   int   done_seen;
   int   nack_seen;
   int   timeout_seen;

   bit   req_steady    = 1'b0;
   bit   rsp_steady    = 1'b0;
   bit   rsp_long_hold = 1'b0;
   bit   last_was_cmd  = 1'b0;
   int   stretch_pct   = 0;
   int   stretch_max   = 1;
   int   stretch_run   = 0;
   int   words_sent    = 0;
   int   cmds_issued   = 0;
   int   csr_writes    = 0;

   i2c_master_byte_engine uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   i2cm_line_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_mon      (csr_bus),
      .fail_count   (fail_count),
      .exp_pending  (exp_pending),
      .engine_busy  (engine_busy),
      .done_seen    (done_seen),
      .nack_seen    (nack_seen),
      .timeout_seen (timeout_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap(input bit steady);
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // scl_in follows a slave that stretches the clock in runs of low ticks
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] wr,
                            input logic ack);
      int   gap;
      logic scl;
      gap = pick_gap(req_steady);
      if (stretch_run > 0) begin
         scl = 1'b0;
         stretch_run--;
      end else if ($urandom_range(0, 99) < stretch_pct) begin
         scl = 1'b0;
         stretch_run = $urandom_range(1, stretch_max) - 1;
      end else begin
         scl = 1'b1;
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.cmd      <= cmd;
      req_bus.wr_byte  <= wr;
      req_bus.send_ack <= ack;
      req_bus.scl_in   <= scl;
      req_bus.sda_in   <= 1'($urandom_range(0, 1));
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
      last_was_cmd = (cmd != CMD_TICK);
   endtask

   // engine_busy seen here is the prediction one word back
   task automatic tick_until_idle();
      logic [CMD_W-1:0] c;
      do begin
         c = ($urandom_range(0, 99) < 4) ? CMD_W'($urandom_range(1, 7)) : CMD_TICK;
         send_word(c, BYTE_W'($urandom), 1'($urandom_range(0, 1)));
      end while (engine_busy || last_was_cmd);
   endtask

   task automatic run_command(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] wr,
                              input logic ack);
      send_word(cmd, wr, ack);
      cmds_issued++;
      tick_until_idle();
   endtask

   task automatic wait_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (exp_pending != 0);
   endtask

   task automatic set_limits(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] h);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= CSR_STRETCH_LIMIT;
      csr_bus.wr_data   <= s;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.reg_index <= CSR_ACK_HOLD;
      csr_bus.wr_data   <= h;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      csr_writes += 2;
   endtask

   task automatic set_stretch(input int pct, input int maxrun);
      stretch_pct = pct;
      stretch_max = maxrun;
      stretch_run = 0;
   endtask

   task automatic run_transaction();
      int n;
      if ($urandom_range(0, 15) == 0)
         req_steady = !req_steady;
      if ($urandom_range(0, 9) == 0) begin
         // loose command outside a start/stop frame
         run_command(CMD_W'($urandom_range(0, 7)), BYTE_W'($urandom),
                     1'($urandom_range(0, 1)));
      end else begin
         run_command(CMD_START, BYTE_W'($urandom), 1'($urandom_range(0, 1)));
         n = $urandom_range(1, 3);
         repeat (n) begin
            if ($urandom_range(0, 1))
               run_command(CMD_WRITE, BYTE_W'($urandom), 1'($urandom_range(0, 1)));
            else
               run_command(CMD_READ, BYTE_W'($urandom), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 7) == 0)
               run_command(CMD_START, BYTE_W'($urandom), 1'($urandom_range(0, 1)));
         end
         run_command(CMD_STOP, BYTE_W'($urandom), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_phase(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] h,
                            input int n_trans, input int pct, input int maxrun);
      wait_results();
      set_limits(s, h);
      set_stretch(pct, maxrun);
      repeat (n_trans) begin
         if (words_sent < ITEMS)
            run_transaction();
      end
   endtask

   // response side: random back-pressure, plus one long hold on request
   initial begin
      int wait_left;
      wait_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_long_hold) begin
            rsp_long_hold = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if ($urandom_range(0, 63) == 0)
               rsp_steady = !rsp_steady;
            wait_left = pick_gap(rsp_steady);
            rsp_bus.ready <= (wait_left == 0);
         end
      end
   end

   initial begin
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("%0t watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("[i2c_master_byte_engine] ERROR");
      $finish;
   end

   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.cmd       <= CMD_TICK;
      req_bus.wr_byte   <= '0;
      req_bus.send_ack  <= 1'b0;
      req_bus.scl_in    <= 1'b1;
      req_bus.sda_in    <= 1'b1;
      csr_bus.valid     <= 1'b0;
      csr_bus.reg_index <= CSR_STRETCH_LIMIT;
      csr_bus.wr_data   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // the long receiver hold lands at the start
      rsp_long_hold = 1'b1;

      // directed: reset limits, idle no-ops, every command, data extremes
      set_stretch(0, 1);
      run_command(CMD_TICK, 8'hFF, 1'b1);
      run_command(3'd5, 8'h00, 1'b0);
      run_command(3'd6, 8'hFF, 1'b1);
      run_command(3'd7, 8'h00, 1'b0);
      run_command(CMD_START, 8'h00, 1'b0);
      run_command(CMD_WRITE, 8'hFF, 1'b0);
      run_command(CMD_WRITE, 8'h00, 1'b1);
      run_command(CMD_READ, 8'h00, 1'b1);
      run_command(CMD_STOP, 8'h00, 1'b0);
      // command offered while busy is dropped
      send_word(CMD_START, 8'h00, 1'b0);
      send_word(CMD_WRITE, 8'h5A, 1'b1);
      tick_until_idle();
      run_command(CMD_STOP, 8'h00, 1'b0);

      // zero limits: first low SCL times out, hold of one tick
      wait_results();
      set_limits(8'd0, 8'd0);
      set_stretch(100, 1);
      run_command(CMD_START, 8'h00, 1'b0);
      run_command(CMD_READ, 8'h00, 1'b1);
      set_stretch(0, 1);
      run_command(CMD_READ, 8'h00, 1'b1);
      run_command(CMD_WRITE, 8'h81, 1'b0);
      set_stretch(100, 1);
      run_command(CMD_READ, 8'h00, 1'b0);

      // top stretch limit with short stretches, NACK read with a short hold
      wait_results();
      set_limits(8'd255, 8'd2);
      set_stretch(0, 1);
      run_command(CMD_READ, 8'h00, 1'b0);
      set_stretch(50, 4);
      run_command(CMD_WRITE, 8'h80, 1'b0);
      set_stretch(0, 1);
      run_command(CMD_STOP, 8'h00, 1'b0);

      // random part
      run_phase(8'd1, 8'd1, 20, 10, 3);
      run_phase(8'd3, 8'd2, 30, 8, 6);
      run_phase(8'd0, 8'd0, 15, 5, 2);
      run_phase(BYTE_W'($urandom_range(1, 20)), BYTE_W'($urandom_range(1, 10)), 40, 6, 23);
      run_phase(STRETCH_LIMIT_RESET, ACK_HOLD_RESET, 20, 4, 10);
      run_phase(8'd20, 8'd8, 40, 3, 25);

      wait_results();
      repeat (8) @(posedge clock);
      $display("covered %0d words, %0d commands, %0d register writes",
               words_sent, cmds_issued, csr_writes);
      $display("completions %0d, slave NACKs %0d, stretch timeouts %0d",
               done_seen, nack_seen, timeout_seen);
      if (fail_count == 0 && exp_pending == 0)
         $display("[i2c_master_byte_engine] OK");
      else
         $display("[i2c_master_byte_engine] ERROR");
      $finish;
   end

endmodule
